// ----- src/hosp_pkg.sv -----
// Shared types, codes and decode functions for the hunk object stream parser.
// Depends on nothing; the front, parser and top files refer to it by scoped names.
package hosp_pkg;

  // Parser states
  typedef enum logic [4:0] {
    ST_ID     = 5'd0,
    ST_SIZE   = 5'd1,
    ST_HNAME  = 5'd2,
    ST_NSECS  = 5'd3,
    ST_FIRST  = 5'd4,
    ST_LAST   = 5'd5,
    ST_SECSIZE = 5'd6,
    ST_NAME   = 5'd7,
    ST_SKIP   = 5'd8,
    ST_RHUNK  = 5'd9,
    ST_RSKIP  = 5'd10,
    ST_RCOUNT = 5'd11,
    ST_ENAME  = 5'd12,
    ST_EVAL   = 5'd13,
    ST_ECVAL  = 5'd14,
    ST_ECSIZE = 5'd15,
    ST_ESKIP  = 5'd16,
    ST_EREF   = 5'd17,
    ST_EHDR   = 5'd18,
    ST_STOP   = 5'd19
  } hosp_state_t;

  // Role tag for each byte
  typedef enum logic [3:0] {
    ROLE_ID         = 4'd0,
    ROLE_END        = 4'd1,
    ROLE_SIZE       = 4'd2,
    ROLE_NAME       = 4'd3,
    ROLE_NSECS      = 4'd4,
    ROLE_FIRST      = 4'd5,
    ROLE_LAST       = 4'd6,
    ROLE_SECSIZE    = 4'd7,
    ROLE_SKIPPED    = 4'd8,
    ROLE_RELOCHUNK  = 4'd9,
    ROLE_RELOCCOUNT = 4'd10,
    ROLE_EXTHDR     = 4'd11,
    ROLE_EXTVALUE   = 4'd12,
    ROLE_COMMONSIZE = 4'd13,
    ROLE_REFCOUNT   = 4'd14,
    ROLE_IGNORED    = 4'd15
  } hosp_role_t;

  // External entry classes
  typedef enum logic [1:0] {
    ECLS_INVALID = 2'd0,
    ECLS_VALUE   = 2'd1,
    ECLS_COMMON  = 2'd2,
    ECLS_REF     = 2'd3
  } hosp_ext_cls_t;

  // Hunk type ids (low 30 bits of the id word)
  localparam logic [29:0] HT_UNIT         = 30'h3E7;
  localparam logic [29:0] HT_NAME         = 30'h3E8;
  localparam logic [29:0] HT_CODE         = 30'h3E9;
  localparam logic [29:0] HT_DATA         = 30'h3EA;
  localparam logic [29:0] HT_RELOC32      = 30'h3EC;
  localparam logic [29:0] HT_RELOC16      = 30'h3ED;
  localparam logic [29:0] HT_RELOC8       = 30'h3EE;
  localparam logic [29:0] HT_EXT          = 30'h3EF;
  localparam logic [29:0] HT_SYMBOL       = 30'h3F0;
  localparam logic [29:0] HT_DEBUG        = 30'h3F1;
  localparam logic [29:0] HT_HEADER       = 30'h3F3;
  localparam logic [29:0] HT_DREL32       = 30'h3F7;
  localparam logic [29:0] HT_DREL16       = 30'h3F8;
  localparam logic [29:0] HT_DREL8        = 30'h3F9;
  localparam logic [29:0] HT_RELOC32SHORT = 30'h3FC;
  localparam logic [29:0] HT_ABSRELOC16   = 30'h3FE;

  // Dense kind code ranges
  localparam logic [29:0] KIND_LO_FIRST = 30'd999;
  localparam logic [29:0] KIND_LO_LAST  = 30'd1011;
  localparam logic [29:0] KIND_HI_FIRST = 30'd1013;
  localparam logic [29:0] KIND_HI_LAST  = 30'd1022;
  localparam logic [29:0] KIND_LO_BASE  = 30'd998;
  localparam logic [29:0] KIND_HI_BASE  = 30'd999;

  // Whole id words
  localparam logic [31:0] END_WORD  = 32'h0000_03F2;
  localparam logic [31:0] STOP_WORD = 32'hFFFF_FFFF;

  // External symbol type bytes
  localparam logic [7:0] SYMT_LOCAL     = 8'd0;
  localparam logic [7:0] SYMT_DEF       = 8'd1;
  localparam logic [7:0] SYMT_ABS       = 8'd2;
  localparam logic [7:0] SYMT_RES       = 8'd3;
  localparam logic [7:0] SYMT_LREF      = 8'd129;
  localparam logic [7:0] SYMT_CMN       = 8'd130;
  localparam logic [7:0] SYMT_WREF      = 8'd131;
  localparam logic [7:0] SYMT_BREF      = 8'd132;
  localparam logic [7:0] SYMT_DEXT32    = 8'd133;
  localparam logic [7:0] SYMT_DEXT16    = 8'd134;
  localparam logic [7:0] SYMT_DEXT8     = 8'd135;
  localparam logic [7:0] SYMT_PCREL_L   = 8'd136;
  localparam logic [7:0] SYMT_PCREL_CMN = 8'd137;
  localparam logic [7:0] SYMT_ABS_WREF  = 8'd138;
  localparam logic [7:0] SYMT_ABS_BREF  = 8'd139;
  localparam logic [7:0] SYMT_DCOMMON0  = 8'd208;
  localparam logic [7:0] SYMT_DCOMMON1  = 8'd209;
  localparam logic [7:0] SYMT_DCOMMON2  = 8'd210;

  // Queue output from front to back
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } hosp_q_t;

  function automatic hosp_ext_cls_t ext_class(input logic [7:0] b);
    hosp_ext_cls_t c;
    unique case (b) inside
      SYMT_LOCAL, SYMT_DEF, SYMT_ABS, SYMT_RES: c = ECLS_VALUE;
      SYMT_CMN, SYMT_PCREL_CMN, SYMT_DCOMMON0, SYMT_DCOMMON1, SYMT_DCOMMON2:
        c = ECLS_COMMON;
      SYMT_LREF, SYMT_WREF, SYMT_BREF, SYMT_DEXT32, SYMT_DEXT16, SYMT_DEXT8,
      SYMT_PCREL_L, SYMT_ABS_WREF, SYMT_ABS_BREF: c = ECLS_REF;
      default: c = ECLS_INVALID;
    endcase
    return c;
  endfunction

  function automatic hosp_state_t fields_state(input hosp_ext_cls_t c);
    hosp_state_t s;
    unique case (c)
      ECLS_VALUE:  s = ST_EVAL;
      ECLS_COMMON: s = ST_ECVAL;
      ECLS_REF:    s = ST_EREF;
      default:     s = ST_EHDR;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] kind_code(input logic [29:0] t);
    logic [4:0] k;
    if (t >= KIND_LO_FIRST && t <= KIND_LO_LAST) begin
      k = 5'(t - KIND_LO_BASE);
    end else if (t >= KIND_HI_FIRST && t <= KIND_HI_LAST) begin
      k = 5'(t - KIND_HI_BASE);
    end else begin
      k = 5'd0;
    end
    return k;
  endfunction

endpackage

// ----- src/hosp_if.sv -----
// Valid/ready channel interfaces for the byte input and the tagged result output.
// Stand-alone; widths follow the fixed field widths.
interface hosp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hosp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  role;
  logic        word_done;
  logic [31:0] word_value;
  logic [4:0]  hunk_kind;
  logic [7:0]  ext_kind;
  logic        bad_ext;

  modport source (output valid, output role, output word_done, output word_value,
                  output hunk_kind, output ext_kind, output bad_ext, input ready);
  modport sink (input valid, input role, input word_done, input word_value,
                input hunk_kind, input ext_kind, input bad_ext, output ready);
endinterface

// ----- src/hosp_front.sv -----
// Front end: accepts stream bytes into a two-byte queue toward the parser.
// Depends on hosp_pkg and hosp_in_if.
module hosp_front (
  input  logic              clk,
  input  logic              rst_n,
  hosp_in_if.sink           in_ch,
  output hosp_pkg::hosp_q_t q,
  input  logic              q_take
);

  logic [7:0] buf_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_take && (cnt_r != 2'd0);
  assign q.valid     = (cnt_r != 2'd0);
  assign q.data      = buf_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= in_ch.data_byte;
    end
  end

endmodule

// ----- src/hosp_parser.sv -----
// Back end: word assembly, hunk state machine and the registered result stage.
// Depends on hosp_pkg and hosp_out_if.
module hosp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  hosp_pkg::hosp_q_t q,
  output logic              q_take,
  hosp_out_if.source        out_ch
);

  hosp_pkg::hosp_state_t state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [29:0] htype_r, htype_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [7:0]  etype_r, etype_nxt;

  logic        out_valid_r, out_valid_nxt;
  hosp_pkg::hosp_role_t out_role_r;
  logic        out_done_r;
  logic [31:0] out_value_r;
  logic [4:0]  out_kind_r;
  logic [7:0]  out_ext_r;
  logic        out_bad_r;

  hosp_pkg::hosp_role_t role;
  logic        done;
  logic [31:0] value;
  logic        bad;
  logic        word_st;
  logic        use_eh;
  logic [31:0] w;
  logic [31:0] w4;
  logic [31:0] rem_dec;
  logic [31:0] rel_cnt;
  logic [7:0]  eh_type;
  logic [23:0] eh_len;
  hosp_pkg::hosp_ext_cls_t eh_cls;
  hosp_pkg::hosp_state_t   eh_state;

  // Take a byte whenever the result register is free or being drained
  assign q_take = q.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    htype_nxt   = htype_r;
    rem_nxt     = rem_r;
    pend_nxt    = pend_r;
    etype_nxt   = etype_r;
    role        = hosp_pkg::ROLE_ID;
    done        = 1'b0;
    value       = 32'd0;
    bad         = 1'b0;
    word_st     = 1'b1;
    use_eh      = 1'b0;

    w       = {partial_r, q.data};
    w4      = {w[29:0], 2'b00};
    rem_dec = rem_r - 32'd1;
    rel_cnt = (htype_r == hosp_pkg::HT_RELOC32SHORT) ? {pend_r[30:0], 1'b0}
                                                      : {pend_r[29:0], 2'b00};
    eh_type = w[31:24];
    eh_len  = w[23:0];
    eh_cls  = hosp_pkg::ext_class(eh_type);
    if (eh_type == 8'd0) begin
      eh_state = hosp_pkg::ST_ID;
    end else if (eh_len != 24'd0) begin
      eh_state = hosp_pkg::ST_ENAME;
    end else begin
      eh_state = hosp_pkg::fields_state(eh_cls);
    end

    unique case (state_r)
      hosp_pkg::ST_STOP: begin
        role    = hosp_pkg::ROLE_IGNORED;
        word_st = 1'b0;
      end
      hosp_pkg::ST_SKIP, hosp_pkg::ST_RSKIP, hosp_pkg::ST_ESKIP: begin
        role        = hosp_pkg::ROLE_SKIPPED;
        word_st     = 1'b0;
        rem_nxt     = rem_dec;
        phase_nxt   = 2'd0;
        partial_nxt = 24'd0;
        if (rem_dec == 32'd0) begin
          if (state_r == hosp_pkg::ST_SKIP) begin
            state_nxt = hosp_pkg::ST_ID;
          end else if (state_r == hosp_pkg::ST_RSKIP) begin
            state_nxt = hosp_pkg::ST_RCOUNT;
          end else begin
            state_nxt = hosp_pkg::ST_EHDR;
          end
        end
      end
      hosp_pkg::ST_SIZE: role = hosp_pkg::ROLE_SIZE;
      hosp_pkg::ST_HNAME, hosp_pkg::ST_NAME, hosp_pkg::ST_ENAME: role = hosp_pkg::ROLE_NAME;
      hosp_pkg::ST_NSECS: role = hosp_pkg::ROLE_NSECS;
      hosp_pkg::ST_FIRST: role = hosp_pkg::ROLE_FIRST;
      hosp_pkg::ST_LAST: role = hosp_pkg::ROLE_LAST;
      hosp_pkg::ST_SECSIZE: role = hosp_pkg::ROLE_SECSIZE;
      hosp_pkg::ST_RHUNK: role = hosp_pkg::ROLE_RELOCHUNK;
      hosp_pkg::ST_RCOUNT: role = hosp_pkg::ROLE_RELOCCOUNT;
      hosp_pkg::ST_EHDR: role = hosp_pkg::ROLE_EXTHDR;
      hosp_pkg::ST_EVAL, hosp_pkg::ST_ECVAL: role = hosp_pkg::ROLE_EXTVALUE;
      hosp_pkg::ST_ECSIZE: role = hosp_pkg::ROLE_COMMONSIZE;
      hosp_pkg::ST_EREF: role = hosp_pkg::ROLE_REFCOUNT;
      default: role = hosp_pkg::ROLE_ID;
    endcase

    if (word_st) begin
      if (phase_r != 2'd3) begin
        partial_nxt = {partial_r[15:0], q.data};
        phase_nxt   = phase_r + 2'd1;
      end else begin
        phase_nxt   = 2'd0;
        partial_nxt = 24'd0;
        done        = 1'b1;
        value       = w;
        unique case (state_r)
          hosp_pkg::ST_SIZE: begin
            unique case (htype_r) inside
              hosp_pkg::HT_HEADER: begin
                if (w != 32'd0) begin
                  rem_nxt   = w;
                  state_nxt = hosp_pkg::ST_HNAME;
                end else begin
                  state_nxt = hosp_pkg::ST_NSECS;
                end
              end
              hosp_pkg::HT_NAME: begin
                rem_nxt   = w;
                state_nxt = (w != 32'd0) ? hosp_pkg::ST_NAME : hosp_pkg::ST_ID;
              end
              hosp_pkg::HT_UNIT, hosp_pkg::HT_CODE, hosp_pkg::HT_DATA,
              hosp_pkg::HT_DEBUG: begin
                rem_nxt   = w4;
                state_nxt = (w4 != 32'd0) ? hosp_pkg::ST_SKIP : hosp_pkg::ST_ID;
              end
              hosp_pkg::HT_RELOC32, hosp_pkg::HT_RELOC16, hosp_pkg::HT_RELOC8,
              hosp_pkg::HT_DREL32, hosp_pkg::HT_DREL16, hosp_pkg::HT_DREL8,
              hosp_pkg::HT_SYMBOL, hosp_pkg::HT_ABSRELOC16,
              hosp_pkg::HT_RELOC32SHORT: begin
                pend_nxt  = w;
                state_nxt = (w != 32'd0) ? hosp_pkg::ST_RHUNK : hosp_pkg::ST_ID;
              end
              hosp_pkg::HT_EXT: use_eh = 1'b1;
              default: state_nxt = hosp_pkg::ST_ID;
            endcase
          end
          hosp_pkg::ST_HNAME: begin
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              state_nxt = hosp_pkg::ST_NSECS;
            end
          end
          hosp_pkg::ST_NAME, hosp_pkg::ST_SECSIZE: begin
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              state_nxt = hosp_pkg::ST_ID;
            end
          end
          hosp_pkg::ST_NSECS: begin
            rem_nxt   = w;
            state_nxt = hosp_pkg::ST_FIRST;
          end
          hosp_pkg::ST_FIRST: state_nxt = hosp_pkg::ST_LAST;
          hosp_pkg::ST_LAST: begin
            state_nxt = (rem_r != 32'd0) ? hosp_pkg::ST_SECSIZE : hosp_pkg::ST_ID;
          end
          hosp_pkg::ST_RHUNK: begin
            rem_nxt   = rel_cnt;
            state_nxt = (rel_cnt != 32'd0) ? hosp_pkg::ST_RSKIP : hosp_pkg::ST_RCOUNT;
          end
          hosp_pkg::ST_RCOUNT: begin
            pend_nxt  = w;
            state_nxt = (w != 32'd0) ? hosp_pkg::ST_RHUNK : hosp_pkg::ST_ID;
          end
          hosp_pkg::ST_ENAME: begin
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              state_nxt = hosp_pkg::fields_state(hosp_pkg::ext_class(etype_r));
            end
          end
          hosp_pkg::ST_EVAL: state_nxt = hosp_pkg::ST_EHDR;
          hosp_pkg::ST_ECVAL: state_nxt = hosp_pkg::ST_ECSIZE;
          hosp_pkg::ST_ECSIZE, hosp_pkg::ST_EREF: begin
            rem_nxt   = w4;
            state_nxt = (w4 != 32'd0) ? hosp_pkg::ST_ESKIP : hosp_pkg::ST_EHDR;
          end
          hosp_pkg::ST_EHDR: use_eh = 1'b1;
          default: begin
            // id word, also taken for any undefined state code
            htype_nxt = w[29:0];
            if (w == hosp_pkg::STOP_WORD) begin
              state_nxt = hosp_pkg::ST_STOP;
            end else if (w == hosp_pkg::END_WORD) begin
              role      = hosp_pkg::ROLE_END;
              state_nxt = hosp_pkg::ST_ID;
            end else begin
              state_nxt = hosp_pkg::ST_SIZE;
            end
          end
        endcase

        // external entry header: type byte in the top, name length below
        if (use_eh) begin
          etype_nxt = eh_type;
          state_nxt = eh_state;
          if (eh_type != 8'd0) begin
            rem_nxt = {8'd0, eh_len};
            bad     = (eh_cls == hosp_pkg::ECLS_INVALID);
          end
        end
      end
    end

    if (q_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hosp_pkg::ST_ID;
      phase_r     <= 2'd0;
      partial_r   <= 24'd0;
      htype_r     <= 30'd0;
      rem_r       <= 32'd0;
      pend_r      <= 32'd0;
      etype_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_take) begin
        state_r   <= state_nxt;
        phase_r   <= phase_nxt;
        partial_r <= partial_nxt;
        htype_r   <= htype_nxt;
        rem_r     <= rem_nxt;
        pend_r    <= pend_nxt;
        etype_r   <= etype_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_role_r  <= role;
      out_done_r  <= done;
      out_value_r <= value;
      out_kind_r  <= hosp_pkg::kind_code(htype_nxt);
      out_ext_r   <= etype_nxt;
      out_bad_r   <= bad;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.role       = out_role_r;
  assign out_ch.word_done  = out_done_r;
  assign out_ch.word_value = out_value_r;
  assign out_ch.hunk_kind  = out_kind_r;
  assign out_ch.ext_kind   = out_ext_r;
  assign out_ch.bad_ext    = out_bad_r;

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hosp_pkg::ST_STOP |=> state_r == hosp_pkg::ST_STOP)
    else $error("parser left the stopped state");

  a_word_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && done) |=> phase_r == 2'd0)
    else $error("byte phase not restarted after a full word");

  a_ignored_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_role_r == hosp_pkg::ROLE_IGNORED) |-> !out_done_r)
    else $error("ignored byte reported a completed word");

  a_bad_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_done_r &&
      (out_role_r == hosp_pkg::ROLE_SIZE || out_role_r == hosp_pkg::ROLE_EXTHDR)))
    else $error("bad external type flagged off a header word");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> out_value_r == 32'd0)
    else $error("word value nonzero on a partial byte");

endmodule

// ----- src/hunk_object_stream_parser_top.sv -----
// Top level of the hunk object stream parser: byte queue in front of the parser.
// Depends on hosp_pkg, hosp_if, hosp_front and hosp_parser.
//
// Feed the object file one byte per accepted word on in_ch; every byte yields exactly
// one tagged result on out_ch, in order. Sustained rate is one byte per clock: a new byte
// is taken each cycle as long as the result register is free or being drained. A byte
// accepted on in_ch is first written into the two-entry input queue; once the parser takes
// it, its result is registered in the result stage and then offered on out_ch. in_ch.ready
// depends only on the queue fill, with no combinational path from out_ch.ready; a stall on
// out_ch reaches the input only when the queue has filled up. After an id word of all ones
// every later byte is tagged ignored until reset.
module hunk_object_stream_parser_top (
  input logic         clk,
  input logic         rst_n,
  hosp_in_if.sink     in_ch,
  hosp_out_if.source  out_ch
);

  hosp_pkg::hosp_q_t q;
  logic              q_take;

  hosp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q      (q),
    .q_take (q_take)
  );

  hosp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .q      (q),
    .q_take (q_take),
    .out_ch (out_ch)
  );

endmodule
